// ===== hw/rtl/crcdfr_pkg.sv =====
// Shared types, register indexes and the CRC16/MODBUS byte update for the deframer.
// No dependencies; every other file of the deframer but the RAM imports this package.
package crcdfr_pkg;

  localparam logic [7:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [7:0] REG_HEADER_SECOND = 8'd1;

  localparam logic [7:0]  HEADER_FIRST_RESET  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RESET = 8'h55;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'hA001;

  // Handover from the receiver to the emitter.
  typedef struct packed {
    logic       start;
    logic [7:0] length;
    logic [7:0] command;
    logic [7:0] sequence_no;
  } frame_ctrl_t;

  // Reflected CRC16 update by one byte, one bit per step.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crc16_framed_packet_deframer.sv =====
// CRC16/MODBUS framed packet deframer, top level; depends on crcdfr_pkg and its submodules.
// Throughput: one received byte per cycle while a frame is being parsed.
// After the final CRC byte of a good frame the input stalls while the payload drains;
// each result passes the registered RAM read and then the output register, and output stalls
// hold the drain. The one result of an empty frame skips the RAM read.
// Reset (synchronous, rst high): hunt restarts, headers return to AA and 55 hex.
module crc16_framed_packet_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] command,
  output logic [7:0] sequence_res,
  output logic [5:0] payload_length,
  output logic [4:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       last
);
  import crcdfr_pkg::*;

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  // The payload of the frame in flight lives in a small RAM. The receiver
  // writes it while the frame arrives; the emitter reads it back in order once
  // the CRC has matched. Input transactions are held off for the whole of
  // emission, so the write and read sides never touch the same frame at once
  // and no forwarding is needed.
  frame_ctrl_t   ctrl;
  logic          emit_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Configuration writes are always taken; the user must write only while idle, unchecked.
  assign cfg_ready = 1'b1;

  crcdfr_rx #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_rx (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ctrl      (ctrl),
    .emit_done (emit_done)
  );

  crcdfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The emitter keeps one output register; a finished result may wait there
  // while the next frame is already being received.
  crcdfr_emit #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CNT_W       (CNT_W)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .emit_done      (emit_done),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .command        (command),
    .sequence_res   (sequence_res),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .byte_valid     (byte_valid),
    .last           (last)
  );

  // Payload reads only happen while input transactions are held off.
  a_read_blocks_input : assert property (@(posedge clk) disable iff (rst)
    ram_re |-> !in_ready)
    else $error("payload RAM read while input transactions are open");

  // The RAM is never written and read in the same cycle.
  a_no_write_during_read : assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("payload RAM written during emission");

  // An empty result is always the last one of its frame.
  a_empty_is_last : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> last)
    else $error("empty result not marked last");

  // A frame start is never signalled while an earlier frame is still draining.
  a_start_only_when_open : assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> in_ready)
    else $error("frame start without an input transaction");

endmodule

// ===== hw/rtl/crcdfr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module crcdfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/crcdfr_rx.sv =====
// Frame receiver: header hunt, header fields, payload write into the RAM and CRC check.
// Depends on crcdfr_pkg; drives the write port of the payload RAM.
module crcdfr_rx #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [7:0]               cfg_index,
  input  logic [7:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [7:0]               ram_wdata,
  output crcdfr_pkg::frame_ctrl_t  ctrl,
  input  logic                     emit_done
);
  import crcdfr_pkg::*;

  typedef enum logic [8:0] {
    S_HUNT1   = 9'b000000001,
    S_HUNT2   = 9'b000000010,
    S_LEN     = 9'b000000100,
    S_CMD     = 9'b000001000,
    S_SEQ     = 9'b000010000,
    S_PAYLOAD = 9'b000100000,
    S_CRCLO   = 9'b001000000,
    S_CRCHI   = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_t;

  state_t           state;
  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [7:0]       frame_length;
  logic [7:0]       frame_command;
  logic [7:0]       frame_sequence;
  logic [15:0]      running_crc;
  logic [7:0]       crc_low;
  logic [CNT_W-1:0] wr_cnt;
  logic             accept;
  logic [15:0]      crc_next;
  logic             crc_good;

  assign in_ready = (state != S_EMIT);
  assign accept   = in_valid && in_ready;
  assign crc_next = crc16_feed(running_crc, rx_byte);
  assign crc_good = ({rx_byte, crc_low} == running_crc);

  assign ram_we    = accept && (state == S_PAYLOAD);
  assign ram_waddr = wr_cnt[AW-1:0];
  assign ram_wdata = rx_byte;

  assign ctrl.start       = accept && (state == S_CRCHI) && crc_good;
  assign ctrl.length      = frame_length;
  assign ctrl.command     = frame_command;
  assign ctrl.sequence_no = frame_sequence;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_HUNT1;
      header_first   <= HEADER_FIRST_RESET;
      header_second  <= HEADER_SECOND_RESET;
      running_crc    <= CRC_INIT;
      wr_cnt         <= '0;
      frame_length   <= '0;
      frame_command  <= '0;
      frame_sequence <= '0;
      crc_low        <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_HEADER_FIRST) begin
          header_first <= cfg_data;
        end else if (cfg_index == REG_HEADER_SECOND) begin
          header_second <= cfg_data;
        end
      end
      if (accept) begin
        case (state)
          S_HUNT1: begin
            if (rx_byte == header_first) begin
              state <= S_HUNT2;
            end
          end
          S_HUNT2: begin
            // The second header is tested first, so equal sync bytes still match.
            if (rx_byte == header_second) begin
              state       <= S_LEN;
              running_crc <= CRC_INIT;
            end else if (rx_byte != header_first) begin
              state <= S_HUNT1;
            end
          end
          S_LEN: begin
            if (rx_byte > 8'(MAX_PAYLOAD)) begin
              state <= S_HUNT1;
            end else begin
              frame_length <= rx_byte;
              running_crc  <= crc_next;
              state        <= S_CMD;
            end
          end
          S_CMD: begin
            frame_command <= rx_byte;
            running_crc   <= crc_next;
            state         <= S_SEQ;
          end
          S_SEQ: begin
            frame_sequence <= rx_byte;
            running_crc    <= crc_next;
            wr_cnt         <= '0;
            state          <= (frame_length == 8'd0) ? S_CRCLO : S_PAYLOAD;
          end
          S_PAYLOAD: begin
            running_crc <= crc_next;
            wr_cnt      <= wr_cnt + 1'b1;
            if (8'(wr_cnt) + 8'd1 == frame_length) begin
              state <= S_CRCLO;
            end
          end
          S_CRCLO: begin
            crc_low <= rx_byte;
            state   <= S_CRCHI;
          end
          S_CRCHI: begin
            state <= crc_good ? S_EMIT : S_HUNT1;
          end
          default: begin
            state <= S_HUNT1;
          end
        endcase
      end else if ((state == S_EMIT) && emit_done) begin
        state <= S_HUNT1;
      end
    end
  end

endmodule

// ===== hw/rtl/crcdfr_emit.sv =====
// Result emitter: reads the payload RAM in order and feeds the output register.
// Depends on crcdfr_pkg; drives the read port of the payload RAM.
module crcdfr_emit #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  crcdfr_pkg::frame_ctrl_t  ctrl,
  output logic                     emit_done,
  output logic                     ram_re,
  output logic [AW-1:0]            ram_raddr,
  input  logic [7:0]               ram_rdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               command,
  output logic [7:0]               sequence_res,
  output logic [5:0]               payload_length,
  output logic [4:0]               byte_index,
  output logic [7:0]               payload_byte,
  output logic                     byte_valid,
  output logic                     last
);
  import crcdfr_pkg::*;

  logic             active;
  logic             rd_pend;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] pend_idx;
  logic             out_free;
  logic             empty_frame;
  logic             load;
  logic             load_empty;
  logic             pend_last;

  assign out_free    = !out_valid || out_ready;
  assign empty_frame = (ctrl.length == 8'd0);
  // The RAM output register holds its word until the next read, so a read is
  // issued only once the word in hand moves on.
  assign load        = active && rd_pend && out_free;
  assign load_empty  = active && empty_frame && out_free;
  assign pend_last   = (8'(pend_idx) + 8'd1 == ctrl.length);
  assign ram_re      = active && (8'(rd_cnt) != ctrl.length) && (!rd_pend || load);
  assign ram_raddr   = rd_cnt[AW-1:0];
  assign emit_done   = load_empty || (load && pend_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rd_pend   <= 1'b0;
      rd_cnt    <= '0;
      pend_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.start) begin
        active  <= 1'b1;
        rd_cnt  <= '0;
        rd_pend <= 1'b0;
      end else begin
        if (emit_done) begin
          active <= 1'b0;
        end
        if (ram_re) begin
          rd_cnt   <= rd_cnt + 1'b1;
          pend_idx <= rd_cnt;
          rd_pend  <= 1'b1;
        end else if (load) begin
          rd_pend <= 1'b0;
        end
      end
      if (load || load_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      command        <= ctrl.command;
      sequence_res   <= ctrl.sequence_no;
      payload_length <= ctrl.length[5:0];
      byte_index     <= 5'(pend_idx);
      payload_byte   <= ram_rdata;
      byte_valid     <= 1'b1;
      last           <= pend_last;
    end else if (load_empty) begin
      command        <= ctrl.command;
      sequence_res   <= ctrl.sequence_no;
      payload_length <= 6'd0;
      byte_index     <= 5'd0;
      payload_byte   <= 8'd0;
      byte_valid     <= 1'b0;
      last           <= 1'b1;
    end
  end

endmodule

// ===== tb/crc16_framed_packet_deframer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CRC16/MODBUS framed packet deframer.
// Depends on crcdfr_pkg (register indexes, reset headers, CRC constants) and the deframer RTL.

module crc16_framed_packet_deframer_test;
  import crcdfr_pkg::*;

  // The instance keeps its default payload limit; the predictor mirrors it here.
  localparam int PAYLOAD_LIMIT = 32;
  // Cycles allowed after the last due result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 4;
  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;
  // Highest register index; nothing is mapped there, so a write to it must be ignored.
  localparam logic [7:0] REG_UNMAPPED_TOP = 8'hFF;

  typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, IN_FRAME} hunt_state_e;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_kind_e;

  // One deframed result, in the order of the output ports.
  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] seq_no;
    logic [5:0] length;
    logic [4:0] index;
    logic [7:0] value;
    logic       valid;
    logic       fin;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] command;
  logic [7:0] sequence_res;
  logic [5:0] payload_length;
  logic [4:0] byte_index;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;

  crc16_framed_packet_deframer #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .sequence_res  (sequence_res),
    .payload_length(payload_length),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .byte_valid    (byte_valid),
    .last          (last)
  );

  always #6 clk = ~clk;

  // Results of good frames that the deframer still owes us, oldest first.
  frame_byte_t frame_bytes_due[$];

  int unsigned fault_count = 0;
  int unsigned sent_count = 0;
  int unsigned idle_run = 0;
  int unsigned stall_left = 0;
  // When set, neither the sender nor the receiver inserts idle cycles.
  bit          steady = 1'b0;

  // Mirror of the deframer: its header registers and its hunt and frame state.
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  hunt_state_e hunt;
  int unsigned body_pos;
  logic [7:0]  frm_len;
  logic [7:0]  frm_cmd;
  logic [7:0]  frm_seq;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  logic [7:0]  pay_mem [PAYLOAD_LIMIT];

  // CRC16/MODBUS, processed one bit at a time: the incoming bit is folded into the
  // feedback term rather than the whole byte being xored in up front.
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  // Idle length for either side: mostly none or a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic restart_hunt();
    hunt     = SEEK_FIRST;
    body_pos = 0;
    crc_acc  = CRC_INIT;
  endtask

  // Advances the mirror by one accepted byte and queues the results of a good frame.
  task automatic deframe_byte(input logic [7:0] b);
    frame_byte_t r;
    case (hunt)
      SEEK_SECOND: begin
        // The second header is tested first, so equal sync bytes still lock on.
        // A repeat of the first header keeps the hunt here; anything else breaks sync
        // and is not looked at again as a possible first header.
        if (b == hdr_second) begin
          hunt     = IN_FRAME;
          body_pos = 0;
          crc_acc  = CRC_INIT;
        end else if (b != hdr_first) begin
          restart_hunt();
        end
      end
      IN_FRAME: begin
        if (body_pos == 0) begin
          if (b > PAYLOAD_LIMIT) begin
            // Oversize length: the frame is abandoned on the length byte itself.
            restart_hunt();
          end else begin
            frm_len  = b;
            crc_acc  = modbus_crc_byte(crc_acc, b);
            body_pos = 1;
          end
        end else if (body_pos == 1) begin
          frm_cmd  = b;
          crc_acc  = modbus_crc_byte(crc_acc, b);
          body_pos = 2;
        end else if (body_pos == 2) begin
          frm_seq  = b;
          crc_acc  = modbus_crc_byte(crc_acc, b);
          body_pos = 3;
        end else if (body_pos < 3 + frm_len) begin
          pay_mem[body_pos - 3] = b;
          crc_acc  = modbus_crc_byte(crc_acc, b);
          body_pos = body_pos + 1;
        end else if (body_pos == 3 + frm_len) begin
          crc_lo   = b;
          body_pos = body_pos + 1;
        end else begin
          // High CRC byte: a match releases the frame, a mismatch drops it silently.
          if ({b, crc_lo} == crc_acc) begin
            if (frm_len == 8'd0) begin
              r = '{frm_cmd, frm_seq, 6'd0, 5'd0, 8'd0, 1'b0, 1'b1};
              frame_bytes_due.push_back(r);
            end else begin
              for (int k = 0; k < frm_len; k++) begin
                r = '{frm_cmd, frm_seq, frm_len[5:0], 5'(k), pay_mem[k], 1'b1,
                      (k + 1 == frm_len)};
                frame_bytes_due.push_back(r);
              end
            end
          end
          restart_hunt();
        end
      end
      default: begin
        restart_hunt();
        if (b == hdr_first) begin
          hunt = SEEK_SECOND;
        end
      end
    endcase
  endtask

  // Every transaction on the input and configuration channels is fed to the mirror at the
  // edge where it happens, so the mirror sees exactly the order the deframer sees.
  always @(posedge clk) begin
    if (rst) begin
      hdr_first  = HEADER_FIRST_RESET;
      hdr_second = HEADER_SECOND_RESET;
      frm_len    = 8'd0;
      frm_cmd    = 8'd0;
      frm_seq    = 8'd0;
      crc_lo     = 8'd0;
      restart_hunt();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEADER_FIRST) begin
          hdr_first = cfg_data;
        end else if (cfg_index == REG_HEADER_SECOND) begin
          hdr_second = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte);
      end
    end
  end

  task automatic note_fault(input string why, input frame_byte_t want, input frame_byte_t got);
    if (fault_count < REPORT_LIMIT) begin
      $display("[%0t] %s: want cmd=%h seq=%h len=%0d idx=%0d byte=%h valid=%b last=%b",
               $time, why, want.cmd, want.seq_no, want.length, want.index, want.value,
               want.valid, want.fin);
      $display("    got cmd=%h seq=%h len=%0d idx=%0d byte=%h valid=%b last=%b",
               got.cmd, got.seq_no, got.length, got.index, got.value, got.valid, got.fin);
    end
    fault_count++;
  endtask

  // Each output transaction is compared field by field with the oldest result due.
  always @(posedge clk) begin : check_results
    frame_byte_t got;
    frame_byte_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{command, sequence_res, payload_length, byte_index, payload_byte, byte_valid,
              last};
      if (frame_bytes_due.size() == 0) begin
        note_fault("result with nothing due", '0, got);
      end else begin
        want = frame_bytes_due.pop_front();
        if (got.cmd !== want.cmd || got.seq_no !== want.seq_no ||
            got.length !== want.length || got.index !== want.index ||
            got.value !== want.value || got.valid !== want.valid ||
            got.fin !== want.fin) begin
          note_fault("result mismatch", want, got);
        end
      end
    end
  end

  // Receiver: ready drops for random stretches unless the steady mode is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 4) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction anywhere means the block is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Offers one byte after an optional gap and returns at the edge where it is taken.
  // Valid is left high so that back-to-back bytes need no second assignment in a step.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Holds the sender back until every result due has been taken, then lets the block settle.
  // The first edge lets the mirror absorb a byte taken at the edge this was called from.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends a complete frame under the current headers, with a correct or a damaged CRC.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [7:0] seq, input fill_kind_e fill,
                            input bit damage);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(len);
    crc = modbus_crc_byte(crc, len);
    send_byte(cmd);
    crc = modbus_crc_byte(crc, cmd);
    send_byte(seq);
    crc = modbus_crc_byte(crc, seq);
    for (int k = 0; k < len; k++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_RAMP: b = 8'(k * 8 + 7);
        default:   b = 8'($urandom_range(0, 255));
      endcase
      crc = modbus_crc_byte(crc, b);
      send_byte(b);
    end
    if (damage) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // Zero-length frame under the reset headers: one result, no data, last set.
  task automatic test_empty_frame();
    send_frame(8'd0, 8'hFF, 8'h00, FILL_ZERO, 1'b0);
  endtask

  // A frame whose CRC is wrong must vanish without a single result.
  task automatic test_bad_crc();
    send_frame(8'd0, 8'h3C, 8'hC3, FILL_ZERO, 1'b1);
  endtask

  // An extra first header in front of the pair must not lose the frame.
  task automatic test_repeated_first_header();
    send_byte(hdr_first);
    send_frame(8'd1, 8'h00, 8'hFF, FILL_ONES, 1'b0);
  endtask

  // A stray byte after the first header breaks sync; the second header on its own is ignored.
  task automatic test_broken_sync();
    send_byte(hdr_first);
    send_byte(8'h12);
    send_byte(hdr_second);
  endtask

  // One more than the payload limit in the length byte throws the hunt back to the start.
  task automatic test_oversize_length();
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(8'(PAYLOAD_LIMIT + 1));
  endtask

  // Several header settings, extremes and equal sync bytes among them. Each setting runs a
  // mix of mostly well-formed frames with random content, plus noise, broken sync and
  // oversize lengths.
  task automatic test_random_traffic();
    logic [7:0]  h1;
    logic [7:0]  h2;
    logic [7:0]  len;
    int unsigned stop_at;
    int unsigned r;
    int unsigned q;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       begin h1 = 8'h00; h2 = 8'hFF; end
        1:       begin h1 = 8'hFF; h2 = 8'h00; end
        2:       begin h1 = 8'h5A; h2 = 8'h5A; end
        5:       begin h1 = HEADER_FIRST_RESET; h2 = HEADER_SECOND_RESET; end
        default: begin h1 = 8'($urandom_range(0, 255)); h2 = 8'($urandom_range(0, 255)); end
      endcase
      // Registers are only touched once the deframer owes nothing.
      wait_drained();
      steady = (p == 1 || p == 4);
      cfg_write(REG_HEADER_FIRST, h1);
      cfg_write(REG_HEADER_SECOND, h2);
      // A write beyond the register list must leave both headers as they are.
      cfg_write((p == 0) ? REG_UNMAPPED_TOP : 8'($urandom_range(2, 254)), ~h1);
      cfg_valid <= 1'b0;
      if (p == 0) begin
        send_frame(8'(PAYLOAD_LIMIT), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), FILL_RAMP, 1'b0);
      end
      stop_at = sent_count + 50;
      while (sent_count < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 10) begin
          send_byte(hdr_first);
          send_byte(hdr_second);
          send_byte(8'($urandom_range(PAYLOAD_LIMIT + 1, 255)));
        end else if (r < 14) begin
          send_byte(hdr_first);
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          if (r < 20) begin
            send_byte(hdr_first);
          end
          // Mostly short payloads; the full limit only now and then.
          q = $urandom_range(0, 99);
          if (q < 10) begin
            len = 8'd0;
          end else if (q < 15) begin
            len = 8'(PAYLOAD_LIMIT);
          end else if (q < 30) begin
            len = 8'($urandom_range(9, PAYLOAD_LIMIT - 1));
          end else begin
            len = 8'($urandom_range(1, 8));
          end
          send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     FILL_RANDOM, $urandom_range(0, 99) < 15);
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_frame();
    test_bad_crc();
    test_repeated_first_header();
    test_broken_sync();
    test_oversize_length();
    test_random_traffic();
    wait_drained();
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
